// ===== design/utf8_glyph_index_decoder_core_macros.svh =====
// assertion macros for the utf8 glyph index decoder
`ifndef UTF8_GLYPH_INDEX_DECODER_CORE_MACROS_SVH
`define UTF8_GLYPH_INDEX_DECODER_CORE_MACROS_SVH

`ifndef SYNTH

// check on every clock edge outside reset
`define UGID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define UGID_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define UGID_ASSERT(label, prop, msg)

`define UGID_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== design/ugid_pkg.sv =====
// types and constants of the utf8 glyph index decoder
package ugid_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [7:0]  t_glyph;
    typedef logic [1:0]  t_used;
    typedef logic [23:0] t_code;

    localparam int     ROM_SIZE       = 134;
    localparam t_glyph GLYPH_FALLBACK = 8'd95;
    localparam t_glyph GLYPH_ROM_BASE = 8'd96;
    localparam t_byte  ASCII_BASE     = 8'd32;
    localparam t_byte  ASCII_MAX      = 8'h7F;

    localparam t_byte  LEAD3_MASK     = 8'hE8;
    localparam t_byte  LEAD3_VALUE    = 8'hE0;
    localparam t_byte  LEAD2_MASK     = 8'hE0;
    localparam t_byte  LEAD2_VALUE    = 8'hC0;

    localparam t_used  USED_ONE       = 2'd1;
    localparam t_used  USED_TWO       = 2'd2;
    localparam t_used  USED_THREE     = 2'd3;

    // packed vietnamese code points, glyph slot is base plus position
    localparam t_code VIET_ROM [ROM_SIZE] = '{
        24'h00C380, 24'h00C381, 24'hE1BAA2, 24'h00C383, 24'hE1BAA0,
        24'h00C482, 24'hE1BAB0, 24'hE1BAAE, 24'hE1BAB2, 24'hE1BAB4,
        24'hE1BAB6, 24'h00C382, 24'hE1BAA6, 24'hE1BAA4, 24'hE1BAA8,
        24'hE1BAAA, 24'hE1BAAC, 24'h00C490, 24'h00C388, 24'h00C389,
        24'hE1BABA, 24'hE1BABC, 24'hE1BAB8, 24'h00C38A, 24'hE1BB80,
        24'hE1BABE, 24'hE1BB82, 24'hE1BB84, 24'hE1BB86, 24'h00C38C,
        24'h00C38D, 24'hE1BB88, 24'h00C4A8, 24'hE1BB8A, 24'h00C392,
        24'h00C393, 24'hE1BB8E, 24'h00C395, 24'hE1BB8C, 24'h00C394,
        24'hE1BB92, 24'hE1BB90, 24'hE1BB94, 24'hE1BB96, 24'hE1BB98,
        24'h00C6A0, 24'hE1BB9C, 24'hE1BB9A, 24'hE1BB9E, 24'hE1BBA0,
        24'hE1BBA2, 24'h00C399, 24'h00C39A, 24'hE1BBA6, 24'h00C5A8,
        24'hE1BBA4, 24'h00C6AF, 24'hE1BBAA, 24'hE1BBA8, 24'hE1BBAC,
        24'hE1BBAE, 24'hE1BBB0, 24'hE1BBB2, 24'h00C39D, 24'hE1BBB6,
        24'hE1BBB8, 24'hE1BBB4, 24'h00C3A0, 24'h00C3A1, 24'hE1BAA3,
        24'h00C3A3, 24'hE1BAA1, 24'h00C483, 24'hE1BAB1, 24'hE1BAAF,
        24'hE1BAB3, 24'hE1BAB5, 24'hE1BAB7, 24'h00C3A2, 24'hE1BAA7,
        24'hE1BAA5, 24'hE1BAA9, 24'hE1BAAB, 24'hE1BAAD, 24'h00C491,
        24'h00C3A8, 24'h00C3A9, 24'hE1BABB, 24'hE1BABD, 24'hE1BAB9,
        24'h00C3AA, 24'hE1BB81, 24'hE1BABF, 24'hE1BB83, 24'hE1BB85,
        24'hE1BB87, 24'h00C3AC, 24'h00C3AD, 24'hE1BB89, 24'h00C4A9,
        24'hE1BB8B, 24'h00C3B2, 24'h00C3B3, 24'hE1BB8F, 24'h00C3B5,
        24'hE1BB8D, 24'h00C3B4, 24'hE1BB93, 24'hE1BB91, 24'hE1BB95,
        24'hE1BB97, 24'hE1BB99, 24'h00C6A1, 24'hE1BB9D, 24'hE1BB9B,
        24'hE1BB9F, 24'hE1BBA1, 24'hE1BBA3, 24'h00C3B9, 24'h00C3BA,
        24'hE1BBA7, 24'h00C5A9, 24'hE1BBA5, 24'h00C6B0, 24'hE1BBAB,
        24'hE1BBA9, 24'hE1BBAD, 24'hE1BBAF, 24'hE1BBB1, 24'hE1BBB3,
        24'h00C3BD, 24'hE1BBB7, 24'hE1BBB9, 24'hE1BBB5
    };

endpackage

// ===== design/utf8_glyph_index_decoder_core.sv =====
// utf8 glyph index decoder: three text bytes in, one glyph slot and byte count out
//
// input channel: i_valid / o_stall with the lead, second and third bytes of the
// current text window; a transfer happens on a rising edge with i_valid high
// and o_stall low
// output channel: o_valid / i_stall with the glyph slot and the number of bytes
// the character used; a transfer happens with o_valid high and i_stall low
// data path: the bytes land in an input register, the decode
// (ascii map, lead byte classification, parallel compare against the
// vietnamese rom) runs between that register and the result register
// throughput is one item per cycle, set by the single registered decode pass,
// but while the receiver stalls the result register holds its payload; one more
// item can still be taken into the input register, after that o_stall rises
// and stays high until the receiver takes the waiting result
// synchronous active low reset empties both registers, dropping any item they
// hold; reset itself produces no item
// the caller advances its text window by o_bytes_used after each transfer

`include "utf8_glyph_index_decoder_core_macros.svh"

module utf8_glyph_index_decoder_core
    import ugid_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_byte  i_lead_byte,
    input  t_byte  i_second_byte,
    input  t_byte  i_third_byte,
    output logic   o_valid,
    input  logic   i_stall,
    output t_glyph o_glyph_index,
    output t_used  o_bytes_used
);

    // input register
    logic   r_in_valid;
    t_byte  r_lead;
    t_byte  r_second;
    t_byte  r_third;

    // result register
    logic   r_out_valid;
    t_glyph r_glyph;
    t_used  r_used;

    // decode path
    logic   out_blocked;
    logic   in_advance;
    logic   in_load;
    t_code  code;
    t_used  form_len;
    logic   rom_hit;
    t_glyph rom_idx;
    t_glyph n_glyph;
    t_used  n_used;

    // result register can take a new item unless it holds one that is stalled
    assign out_blocked = r_out_valid && i_stall;
    assign in_advance  = r_in_valid && !out_blocked;
    // input register refills when empty or when its item moves on
    assign o_stall     = r_in_valid && out_blocked;
    assign in_load     = i_valid && !o_stall;

    // classify the lead byte and pack the code
    always_comb begin
        code     = '0;
        form_len = USED_ONE;
        if ((r_lead & LEAD3_MASK) == LEAD3_VALUE) begin
            code     = {r_lead, r_second, r_third};
            form_len = USED_THREE;
        end else if ((r_lead & LEAD2_MASK) == LEAD2_VALUE) begin
            code     = {8'h00, r_lead, r_second};
            form_len = USED_TWO;
        end
    end

    // parallel compare against the rom, lowest matching slot wins
    always_comb begin
        rom_hit = 1'b0;
        rom_idx = '0;
        for (int k = ROM_SIZE - 1; k >= 0; k--) begin
            if (code == VIET_ROM[k]) begin
                rom_hit = 1'b1;
                rom_idx = t_glyph'(k);
            end
        end
    end

    // final glyph selection
    always_comb begin
        n_glyph = GLYPH_FALLBACK;
        n_used  = USED_ONE;
        if (r_lead > ASCII_MAX) begin
            // a code of zero (other high lead byte) never hits the rom
            if (rom_hit && form_len != USED_ONE) begin
                n_glyph = GLYPH_ROM_BASE + rom_idx;
                n_used  = form_len;
            end
        end else if (r_lead >= ASCII_BASE) begin
            n_glyph = r_lead - ASCII_BASE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (in_advance) begin
                r_in_valid <= 1'b0;
            end
            if (!out_blocked) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_lead   <= i_lead_byte;
            r_second <= i_second_byte;
            r_third  <= i_third_byte;
        end
        if (in_advance) begin
            r_glyph <= n_glyph;
            r_used  <= n_used;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_glyph_index = r_glyph;
    assign o_bytes_used  = r_used;

    // stall toward the sender only with both registers full
    `UGID_ASSERT_ALWAYS(a_stall_full, o_stall |-> (r_in_valid && r_out_valid), "stall not full")
    // a transfer in always leaves an item in the input register
    `UGID_ASSERT(a_load_held, (i_valid && !o_stall) |=> r_in_valid, "accepted item dropped")
    // a two or three byte result always comes from the rom range
    `UGID_ASSERT(a_multi_rom, r_out_valid && r_used[1] |-> r_glyph >= GLYPH_ROM_BASE, "low glyph")
    // byte count is never zero on a valid result
    `UGID_ASSERT(a_used_nonzero, r_out_valid |-> (r_used != 2'd0), "zero byte count")

endmodule

// ===== tb/tb_utf8_glyph_index_decoder_core.sv =====
// self-checking testbench for the utf8 glyph index decoder core
module tb_utf8_glyph_index_decoder_core;
    import ugid_pkg::*;

    localparam int RANDOM_WINDOWS = 930;
    localparam int DIRECTED_COUNT = 21;
    localparam int CHUNK          = 40;

    typedef struct packed {
        t_glyph glyph;
        t_used  used;
    } t_glyph_result;

    // one directed text window; known rows carry an expectation typed in by hand
    typedef struct packed {
        t_byte  lead;
        t_byte  second;
        t_byte  third;
        bit     known;
        t_glyph glyph;
        t_used  used;
    } t_window_row;

    localparam t_window_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{8'h00, 8'h00, 8'h00, 1'b1, GLYPH_FALLBACK, USED_ONE},    // lowest control byte
        '{8'h1F, 8'hFF, 8'hFF, 1'b1, GLYPH_FALLBACK, USED_ONE},    // highest control byte
        '{8'h20, 8'h00, 8'h00, 1'b1, 8'd0,           USED_ONE},    // space
        '{8'h41, 8'hFF, 8'hFF, 1'b1, 8'd33,          USED_ONE},
        '{8'h7E, 8'h55, 8'hAA, 1'b1, 8'd94,          USED_ONE},
        '{8'h7F, 8'h00, 8'h00, 1'b1, GLYPH_FALLBACK, USED_ONE},    // del lands on fallback slot
        '{8'h80, 8'h80, 8'h80, 1'b1, GLYPH_FALLBACK, USED_ONE},    // stray continuation byte
        '{8'hFF, 8'hFF, 8'hFF, 1'b1, GLYPH_FALLBACK, USED_ONE},
        '{8'hC3, 8'h80, 8'h00, 1'b1, GLYPH_ROM_BASE, USED_TWO},    // first rom entry
        '{8'hE1, 8'hBB, 8'hB5, 1'b1, 8'd229,         USED_THREE},  // last rom entry
        '{8'hE1, 8'hBA, 8'hA2, 1'b0, 8'd0,           USED_ONE},
        '{8'hC3, 8'hA0, 8'h41, 1'b0, 8'd0,           USED_ONE},
        '{8'hC6, 8'hB0, 8'hFF, 1'b0, 8'd0,           USED_ONE},
        '{8'hC4, 8'h90, 8'h00, 1'b0, 8'd0,           USED_ONE},
        '{8'hE1, 8'hBB, 8'hB9, 1'b0, 8'd0,           USED_ONE},
        '{8'hE1, 8'hBA, 8'hA3, 1'b0, 8'd0,           USED_ONE},
        '{8'hC3, 8'hFF, 8'h00, 1'b1, GLYPH_FALLBACK, USED_ONE},    // two-byte form, no match
        '{8'hE1, 8'hBA, 8'h00, 1'b1, GLYPH_FALLBACK, USED_ONE},    // three-byte form, no match
        '{8'hF0, 8'h9F, 8'h98, 1'b1, GLYPH_FALLBACK, USED_ONE},    // four-byte lead seen as three
        '{8'hE8, 8'hBA, 8'hA2, 1'b1, GLYPH_FALLBACK, USED_ONE},    // other high lead byte
        '{8'hC0, 8'h80, 8'h00, 1'b1, GLYPH_FALLBACK, USED_ONE}
    };

    // packed vietnamese code points, glyph slot is base plus position
    localparam t_code GLYPH_CODES [134] = '{
        24'h00C380, 24'h00C381, 24'hE1BAA2, 24'h00C383, 24'hE1BAA0,
        24'h00C482, 24'hE1BAB0, 24'hE1BAAE, 24'hE1BAB2, 24'hE1BAB4,
        24'hE1BAB6, 24'h00C382, 24'hE1BAA6, 24'hE1BAA4, 24'hE1BAA8,
        24'hE1BAAA, 24'hE1BAAC, 24'h00C490, 24'h00C388, 24'h00C389,
        24'hE1BABA, 24'hE1BABC, 24'hE1BAB8, 24'h00C38A, 24'hE1BB80,
        24'hE1BABE, 24'hE1BB82, 24'hE1BB84, 24'hE1BB86, 24'h00C38C,
        24'h00C38D, 24'hE1BB88, 24'h00C4A8, 24'hE1BB8A, 24'h00C392,
        24'h00C393, 24'hE1BB8E, 24'h00C395, 24'hE1BB8C, 24'h00C394,
        24'hE1BB92, 24'hE1BB90, 24'hE1BB94, 24'hE1BB96, 24'hE1BB98,
        24'h00C6A0, 24'hE1BB9C, 24'hE1BB9A, 24'hE1BB9E, 24'hE1BBA0,
        24'hE1BBA2, 24'h00C399, 24'h00C39A, 24'hE1BBA6, 24'h00C5A8,
        24'hE1BBA4, 24'h00C6AF, 24'hE1BBAA, 24'hE1BBA8, 24'hE1BBAC,
        24'hE1BBAE, 24'hE1BBB0, 24'hE1BBB2, 24'h00C39D, 24'hE1BBB6,
        24'hE1BBB8, 24'hE1BBB4, 24'h00C3A0, 24'h00C3A1, 24'hE1BAA3,
        24'h00C3A3, 24'hE1BAA1, 24'h00C483, 24'hE1BAB1, 24'hE1BAAF,
        24'hE1BAB3, 24'hE1BAB5, 24'hE1BAB7, 24'h00C3A2, 24'hE1BAA7,
        24'hE1BAA5, 24'hE1BAA9, 24'hE1BAAB, 24'hE1BAAD, 24'h00C491,
        24'h00C3A8, 24'h00C3A9, 24'hE1BABB, 24'hE1BABD, 24'hE1BAB9,
        24'h00C3AA, 24'hE1BB81, 24'hE1BABF, 24'hE1BB83, 24'hE1BB85,
        24'hE1BB87, 24'h00C3AC, 24'h00C3AD, 24'hE1BB89, 24'h00C4A9,
        24'hE1BB8B, 24'h00C3B2, 24'h00C3B3, 24'hE1BB8F, 24'h00C3B5,
        24'hE1BB8D, 24'h00C3B4, 24'hE1BB93, 24'hE1BB91, 24'hE1BB95,
        24'hE1BB97, 24'hE1BB99, 24'h00C6A1, 24'hE1BB9D, 24'hE1BB9B,
        24'hE1BB9F, 24'hE1BBA1, 24'hE1BBA3, 24'h00C3B9, 24'h00C3BA,
        24'hE1BBA7, 24'h00C5A9, 24'hE1BBA5, 24'h00C6B0, 24'hE1BBAB,
        24'hE1BBA9, 24'hE1BBAD, 24'hE1BBAF, 24'hE1BBB1, 24'hE1BBB3,
        24'h00C3BD, 24'hE1BBB7, 24'hE1BBB9, 24'hE1BBB5
    };

    logic   i_clk         = 1'b0;
    logic   i_rst_n       = 1'b0;
    logic   i_valid       = 1'b0;
    logic   i_stall       = 1'b0;
    t_byte  i_lead_byte   = '0;
    t_byte  i_second_byte = '0;
    t_byte  i_third_byte  = '0;
    logic   o_stall;
    logic   o_valid;
    t_glyph o_glyph_index;
    t_used  o_bytes_used;

    t_glyph_result pending_glyphs [$];

    int  mismatches      = 0;
    int  windows_sent    = 0;
    int  glyphs_checked  = 0;
    int  two_byte_hits   = 0;
    int  three_byte_hits = 0;
    int  fallback_glyphs = 0;
    int  input_held      = 0;
    int  hold_off_cycles = 0;
    bit  tx_idle         = 1'b1;
    bit  rx_idle         = 1'b1;

    utf8_glyph_index_decoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_lead_byte   (i_lead_byte),
        .i_second_byte (i_second_byte),
        .i_third_byte  (i_third_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_glyph_index (o_glyph_index),
        .o_bytes_used  (o_bytes_used)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("** utf8_glyph_index_decoder_core: FAILED **");
        $finish;
    end

    // glyph slot and byte count of the character starting at lead
    function automatic t_glyph_result decode_window(t_byte lead, t_byte second, t_byte third);
        t_glyph_result res;
        t_code         code;
        t_used         width;
        bit            found;
        res.glyph = GLYPH_FALLBACK;
        res.used  = USED_ONE;
        found     = 1'b0;
        if (lead > ASCII_MAX) begin
            code  = '0;
            width = USED_ONE;
            if ((lead & LEAD3_MASK) == LEAD3_VALUE) begin
                code  = {lead, second, third};
                width = USED_THREE;
            end else if ((lead & LEAD2_MASK) == LEAD2_VALUE) begin
                code  = {8'h00, lead, second};
                width = USED_TWO;
            end
            // packed code 0 never matches, so other high leads fall through
            for (int k = 0; k < 134; k++) begin
                if (!found && code == GLYPH_CODES[k]) begin
                    found     = 1'b1;
                    res.glyph = GLYPH_ROM_BASE + t_glyph'(k);
                    res.used  = width;
                end
            end
        end else if (lead >= ASCII_BASE) begin
            res.glyph = lead - ASCII_BASE;
        end
        return res;
    endfunction

    // half the windows real characters, some of them one bit off, the rest ascii or noise
    function automatic void draw_window(output t_byte lead, output t_byte second,
                                        output t_byte third);
        logic [23:0] win;
        t_code       code;
        int          pick;
        int          flip;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            code = GLYPH_CODES[$urandom_range(0, 133)];
            if (code[23:16] == 8'h00) begin
                win  = {code[15:0], 8'($urandom)};
                flip = $urandom_range(8, 23);
            end else begin
                win  = code;
                flip = $urandom_range(0, 23);
            end
            if (pick >= 38)
                win = win ^ (24'd1 << flip);
        end else if (pick < 70) begin
            win = {8'($urandom_range(0, 127)), 16'($urandom)};
        end else begin
            win = 24'($urandom);
        end
        {lead, second, third} = win;
    endfunction

    // present one window, junk on the bytes while idle, record the expectation on transfer
    task automatic offer_window(t_byte lead, t_byte second, t_byte third, t_glyph_result want);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        repeat (gap) begin
            i_valid       <= 1'b0;
            i_lead_byte   <= 8'($urandom);
            i_second_byte <= 8'($urandom);
            i_third_byte  <= 8'($urandom);
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_lead_byte   <= lead;
        i_second_byte <= second;
        i_third_byte  <= third;
        do @(posedge i_clk); while (o_stall);
        pending_glyphs.push_back(want);
        windows_sent++;
    endtask

    // sender goes quiet until every outstanding glyph has come back
    task automatic wait_for_glyphs();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_glyphs.size() != 0);
    endtask

    initial begin : stimulus
        t_byte         lead;
        t_byte         second;
        t_byte         third;
        t_glyph_result want;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].known)
                want = '{glyph: DIRECTED_ROWS[r].glyph, used: DIRECTED_ROWS[r].used};
            else
                want = decode_window(DIRECTED_ROWS[r].lead, DIRECTED_ROWS[r].second,
                                     DIRECTED_ROWS[r].third);
            offer_window(DIRECTED_ROWS[r].lead, DIRECTED_ROWS[r].second,
                         DIRECTED_ROWS[r].third, want);
        end
        wait_for_glyphs();

        for (int n = 0; n < RANDOM_WINDOWS; n++) begin
            if (n % CHUNK == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            if (n == 300)
                wait_for_glyphs();
            if (n == 520) begin
                // receiver backs off while the sender keeps pushing at full rate
                wait_for_glyphs();
                hold_off_cycles = 60;
                tx_idle         = 1'b0;
            end
            draw_window(lead, second, third);
            offer_window(lead, second, third, decode_window(lead, second, third));
        end

        wait_for_glyphs();
        repeat (6) @(posedge i_clk);
        $display("%0d windows decoded and checked: %0d two-byte and %0d three-byte rom hits,",
                 glyphs_checked, two_byte_hits, three_byte_hits);
        $display("%0d fallback glyphs, input held off for %0d cycles",
                 fallback_glyphs, input_held);
        if (mismatches == 0 && pending_glyphs.size() == 0) begin
            $display("** utf8_glyph_index_decoder_core: PASSED **");
        end else begin
            $display("** utf8_glyph_index_decoder_core: FAILED **");
        end
        $finish;
    end

    // result side: random back-pressure per glyph, plus the long hold-off on request
    initial begin : glyph_sink
        int wait_cycles;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            wait_cycles = rx_idle ? $urandom_range(0, 5) : 0;
            if (hold_off_cycles != 0) begin
                wait_cycles     = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (wait_cycles != 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_stall)
            input_held++;
    end

    // compare every transfer on the result side with the oldest expectation
    always @(posedge i_clk) begin
        t_glyph_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_glyphs.size() == 0) begin
                $display("%0t: unexpected glyph %0d, bytes used %0d",
                         $time, o_glyph_index, o_bytes_used);
                mismatches++;
            end else begin
                want = pending_glyphs.pop_front();
                glyphs_checked++;
                if (want.used == USED_TWO)
                    two_byte_hits++;
                else if (want.used == USED_THREE)
                    three_byte_hits++;
                else if (want.glyph == GLYPH_FALLBACK)
                    fallback_glyphs++;
                if (o_glyph_index !== want.glyph) begin
                    $display("%0t: glyph index expected %0d, got %0d",
                             $time, want.glyph, o_glyph_index);
                    mismatches++;
                end
                if (o_bytes_used !== want.used) begin
                    $display("%0t: bytes used expected %0d, got %0d",
                             $time, want.used, o_bytes_used);
                    mismatches++;
                end
            end
        end
    end

endmodule

// ===== files.f =====
+incdir+design
design/ugid_pkg.sv
design/utf8_glyph_index_decoder_core.sv
tb/tb_utf8_glyph_index_decoder_core.sv
